### hw/rtl/vvn_pkg.sv
// ----------------------------------------------------------------------------
// vvn_pkg
// Shared types, constants and functions for the view vector normalizer.
// ----------------------------------------------------------------------------
package vvn_pkg;

  localparam int unsigned COORD_W  = 32;  // Q16.16 coordinate
  localparam int unsigned UNIT_W   = 16;  // Q1.15 result
  localparam int unsigned MAG_W    = 21;  // normalized magnitude, [2^20, 2^21)
  localparam int unsigned Q30_W    = 32;  // Q2.30 operand x
  localparam int unsigned Y_W      = 31;  // inverse root, about 2^30 at most
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Z = 2'd2;

  localparam logic [33:0] THREE_Q30 = 34'h0_C000_0000;
  localparam logic [14:0] UNIT_MAX  = 15'h7FFF;

  // Data that rides along with the inverse square root.
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  khi;    // sum of squares >= 2^42
    logic                  degen;
    logic                  last;
  } side_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic                     degenerate;
    logic                     last_out;
  } res_t;

  // 1/sqrt of each half-unit interval midpoint, Q2.30, indexed by x[31:29].
  function automatic logic [Y_W-1:0] rsqrt_seed(input logic [2:0] idx);
    logic [Y_W-1:0] s;
    begin
      case (idx)
        3'd2:    s = 31'd960383678;
        3'd3:    s = 31'd811672583;
        3'd4:    s = 31'd715827883;
        3'd5:    s = 31'd647491016;
        3'd6:    s = 31'd595604590;
        3'd7:    s = 31'd554478330;
        default: s = '0;
      endcase
      return s;
    end
  endfunction

  // Round the product to Q1.15, saturate and apply the sign; a degenerate vector gives zero.
  function automatic logic [UNIT_W-1:0] pack_unit(input logic [MAG_W+Y_W-1:0] prod,
                                                 input logic khi, input logic neg,
                                                 input logic degen);
    logic [MAG_W+Y_W:0] sum;
    logic [17:0]        q;
    logic [14:0]        mag;
    logic [UNIT_W-1:0]  v;
    begin
      sum = {1'b0, prod} + (khi ? (53'd1 << 35) : (53'd1 << 34));
      q   = khi ? {1'b0, sum[52:36]} : sum[52:35];
      mag = (q > 18'(UNIT_MAX)) ? UNIT_MAX : q[14:0];
      v   = neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
      return degen ? '0 : v;
    end
  endfunction

endpackage

### hw/rtl/vvn_if.sv
// ----------------------------------------------------------------------------
// vvn_if
// Valid/ready channels of the view vector normalizer: points in, unit
// vectors out, and the register write channel.
// ----------------------------------------------------------------------------
interface vvn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               last_point;

  modport source(output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink(input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface vvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic               degenerate;
  logic               last_out;

  modport source(output valid, unit_x, unit_y, unit_z, degenerate, last_out, input ready);
  modport sink(input valid, unit_x, unit_y, unit_z, degenerate, last_out, output ready);
endinterface

interface vvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/vvn_rsqrt.sv
// ----------------------------------------------------------------------------
// vvn_rsqrt
// Pipelined inverse square root in Q2.30: table seed, then three Newton
// steps of three multiply stages each. Ten stages, one item per cycle while en is high.
// ----------------------------------------------------------------------------
module vvn_rsqrt import vvn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [Q30_W-1:0] x,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [Y_W-1:0]   y,
  output side_t            out_side
);

  // step boundaries: index 0 is the seed stage, n+1 the end of step n
  logic             vs [0:3];
  logic [Q30_W-1:0] xs [0:3];
  logic [Y_W-1:0]   ys [0:3];
  side_t            ss [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= x;
      ys[0] <= rsqrt_seed(x[31:29]);
      ss[0] <= in_side;
    end
  end

  for (genvar n = 0; n < 3; n++) begin : g_step
    logic             va, vb;
    logic [Q30_W-1:0] xa, xb;
    logic [Y_W-1:0]   ya, yb;
    logic [31:0]      y2a;
    logic [33:0]      tb;
    side_t            sa, sb;
    logic [61:0]      yy;
    logic [63:0]      xy;
    logic [31:0]      f;
    logic [62:0]      yf;

    assign yy = 62'(ys[n]) * 62'(ys[n]);
    assign xy = 64'(xa) * 64'(y2a);
    // step factor is zero once t reaches three
    assign f  = (tb >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - tb);
    assign yf = 63'(yb) * 63'(f);

    always_ff @(posedge clk) begin
      if (rst) begin
        va        <= 1'b0;
        vb        <= 1'b0;
        vs[n + 1] <= 1'b0;
      end else if (en) begin
        va        <= vs[n];
        vb        <= va;
        vs[n + 1] <= vb;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xa        <= xs[n];
        ya        <= ys[n];
        y2a       <= yy[61:30];
        sa        <= ss[n];
        xb        <= xa;
        yb        <= ya;
        tb        <= xy[63:30];
        sb        <= sa;
        xs[n + 1] <= xb;
        ys[n + 1] <= yf[61:31];
        ss[n + 1] <= sb;
      end
    end
  end

  assign out_valid = vs[3];
  assign y         = ys[3];
  assign out_side  = ss[3];

endmodule

### hw/rtl/view_vector_normalizer_top.sv
// ----------------------------------------------------------------------------
// view_vector_normalizer_top
// Unit view vector from each point toward the configured sensor position.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------------
//   cfg     | in  | index, data: sensor_x/y/z register writes
//   pts     | in  | point_x, point_y, point_z (Q16.16), last_point
//   res     | out | unit_x, unit_y, unit_z (Q1.15), degenerate, last_out
//
// One request per cycle is accepted while pts.ready is high; from acceptance
// to res.valid a request passes 7 front stages, 10 inverse-root stages, a
// scale stage and the output register. rst is synchronous and clears all
// valid bits and the sensor registers. A stall on res fills a one-entry skid
// register; pts.ready drops while it is full and the whole pipeline holds.
// cfg is always ready.
// ----------------------------------------------------------------------------
module view_vector_normalizer_top import vvn_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  vvn_cfg_if.sink        cfg,
  vvn_in_if.sink         pts,
  vvn_out_if.source      res
);

  logic signed [COORD_W-1:0] sensor [3];
  logic signed [COORD_W-1:0] point  [3];

  logic en;

  // stage registers
  logic                      v1, v2, v3, v4, v5, v6, v7, vp;
  logic signed [COORD_W:0]   d1   [3];
  logic [COORD_W-1:0]        a2   [3];
  logic [COORD_W-1:0]        a3   [3];
  logic [COORD_W-1:0]        a4   [3];
  logic [COORD_W-1:0]        m3;
  logic [4:0]                p4;
  logic [2:0]                neg2, neg3, neg4;
  logic                      last1, last2, last3, last4;
  logic                      degen4;
  side_t                     side5, side6, side7, sidep;
  logic [2*MAG_W-1:0]        sq6  [3];
  logic [Q30_W-1:0]          x7;
  logic [MAG_W+Y_W-1:0]      prod [3];

  logic                      rv;
  logic [Y_W-1:0]            ry;
  side_t                     rside;

  // output register and skid
  logic                      ov, sv;
  res_t                      obuf, sbuf, res_new;

  // ---------------- configuration ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor[0] <= '0;
      sensor[1] <= '0;
      sensor[2] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SENSOR_X: sensor[0] <= cfg.data;
        REG_SENSOR_Y: sensor[1] <= cfg.data;
        REG_SENSOR_Z: sensor[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------- front pipeline ----------------
  assign en        = !sv;
  assign pts.ready = en;

  assign point[0] = pts.point_x;
  assign point[1] = pts.point_y;
  assign point[2] = pts.point_z;

  logic [COORD_W-1:0] mx01, mmax;
  logic [4:0]         msb;
  logic [51:0]        shifted [3];
  logic [MAG_W-1:0]   mag5    [3];
  logic [2*MAG_W+1:0] ssum;
  side_t              side7_next;

  assign mx01 = (a2[0] > a2[1]) ? a2[0] : a2[1];
  assign mmax = (mx01 > a2[2]) ? mx01 : a2[2];

  always_comb begin
    msb = 5'd20;
    for (int i = 0; i < COORD_W; i++) begin
      if (m3[i]) msb = 5'(i);
    end
  end

  // magnitude * 2^(20 - msb), truncating, lands the largest in [2^20, 2^21)
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shifted[c] = {a4[c], 20'd0} >> p4;
      mag5[c]    = shifted[c][MAG_W-1:0];
    end
  end

  assign ssum = 44'(sq6[0]) + 44'(sq6[1]) + 44'(sq6[2]);

  always_comb begin
    side7_next     = side6;
    side7_next.khi = (ssum[43:42] != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      vp <= 1'b0;
    end else if (en) begin
      v1 <= pts.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      vp <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        d1[c]   <= {sensor[c][COORD_W-1], sensor[c]} - {point[c][COORD_W-1], point[c]};
        neg2[c] <= d1[c][COORD_W];
        a2[c]   <= d1[c][COORD_W] ? COORD_W'(-d1[c]) : COORD_W'(d1[c]);
        a3[c]   <= a2[c];
        a4[c]   <= a3[c];
        side5.mag[c] <= mag5[c];
        sq6[c]  <= 42'(side5.mag[c]) * 42'(side5.mag[c]);
        prod[c] <= 52'(rside.mag[c]) * 52'(ry);
      end
      last1  <= pts.last_point;
      last2  <= last1;
      m3     <= mmax;
      neg3   <= neg2;
      last3  <= last2;
      p4     <= msb;
      degen4 <= (m3 == '0);
      neg4   <= neg3;
      last4  <= last3;
      side5.neg   <= neg4;
      side5.khi   <= 1'b0;
      side5.degen <= degen4;
      side5.last  <= last4;
      side6  <= side5;
      side7  <= side7_next;
      x7     <= (ssum[43:42] != 2'd0) ? ssum[43:12] : ssum[41:10];
      sidep  <= rside;
    end
  end

  vvn_rsqrt u_rsqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v7),
    .x        (x7),
    .in_side  (side7),
    .out_valid(rv),
    .y        (ry),
    .out_side (rside)
  );

  // ---------------- result and output buffer ----------------
  always_comb begin
    res_new.unit_x     = pack_unit(prod[0], sidep.khi, sidep.neg[0], sidep.degen);
    res_new.unit_y     = pack_unit(prod[1], sidep.khi, sidep.neg[1], sidep.degen);
    res_new.unit_z     = pack_unit(prod[2], sidep.khi, sidep.neg[2], sidep.degen);
    res_new.degenerate = sidep.degen;
    res_new.last_out   = sidep.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (res.ready) begin
        obuf <= sbuf;
        sv   <= 1'b0;
      end
    end else if (vp) begin
      if (!ov || res.ready) begin
        obuf <= res_new;
        ov   <= 1'b1;
      end else begin
        sbuf <= res_new;
        sv   <= 1'b1;
      end
    end else if (res.ready) begin
      ov <= 1'b0;
    end
  end

  assign res.valid      = ov;
  assign res.unit_x     = obuf.unit_x;
  assign res.unit_y     = obuf.unit_y;
  assign res.unit_z     = obuf.unit_z;
  assign res.degenerate = obuf.degenerate;
  assign res.last_out   = obuf.last_out;

endmodule

### tb/tb_view_vector_normalizer_top.sv
// ----------------------------------------------------------------------------
// tb_view_vector_normalizer_top
// Drives points and sensor register writes into the normalizer. A scoreboard
// works out each unit view vector in integer arithmetic and compares it
// field by field with what comes out. Flow control on both sides is
// randomized.
// ----------------------------------------------------------------------------
module tb_view_vector_normalizer_top;
  import vvn_pkg::*;

  localparam int PIPE_LATENCY = 19;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 233;

  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped, writes dropped

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } pt_t;

  // --------------------------------------------------------------------------
  class unit_vector_board;
    logic signed [31:0] sensor [3];
    res_t               owed [$];
    int                 errors;
    // 1/sqrt of each half-unit interval midpoint, Q2.30
    bit [63:0]          seeds [8] = '{0, 0, 960383678, 811672583, 715827883,
                                      647491016, 595604590, 554478330};

    function new();
      sensor = '{0, 0, 0};
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_SENSOR_X: sensor[0] = v;
        REG_SENSOR_Y: sensor[1] = v;
        REG_SENSOR_Z: sensor[2] = v;
        default: ;
      endcase
    endfunction

    function void note_point(pt_t p);
      longint            diff [3];
      longint unsigned   mag [3];
      bit                neg [3];
      longint unsigned   mx, sos, xq, yq, y2, t, f, q;
      int unsigned       k, sh;
      logic signed [31:0] pc [3];
      res_t              want;
      pc = '{p.x, p.y, p.z};
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        diff[i] = longint'(sensor[i]) - longint'(pc[i]);
        neg[i]  = diff[i] < 0;
        mag[i]  = neg[i] ? longint'(-diff[i]) : diff[i];
        if (mag[i] > mx) mx = mag[i];
      end
      want.last_out = p.last;
      if (mx == 0) begin
        want.unit_x = '0;
        want.unit_y = '0;
        want.unit_z = '0;
        want.degenerate = 1'b1;
        owed.push_back(want);
        return;
      end
      // bring the largest magnitude into [2^20, 2^21)
      while (mx < (64'd1 << 20)) begin
        mx = mx << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      while (mx >= (64'd1 << 21)) begin
        mx = mx >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      sos = 0;
      for (int i = 0; i < 3; i++) sos += mag[i] * mag[i];
      k  = (sos >= (64'd1 << 42)) ? 42 : 40;
      xq = sos >> (k - 30);
      yq = seeds[(xq >> 29) & 7];
      for (int n = 0; n < 3; n++) begin
        y2 = (yq * yq) >> 30;
        t  = (xq * y2) >> 30;
        f  = (t >= 64'hC000_0000) ? 64'd0 : (64'hC000_0000 - t);
        yq = (yq * f) >> 31;
      end
      sh = 15 + k / 2;
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * yq + (64'd1 << (sh - 1))) >> sh;
        if (q > 32767) q = 32767;
        mag[i] = q;
      end
      want.unit_x = neg[0] ? 16'(-mag[0]) : 16'(mag[0]);
      want.unit_y = neg[1] ? 16'(-mag[1]) : 16'(mag[1]);
      want.unit_z = neg[2] ? 16'(-mag[2]) : 16'(mag[2]);
      want.degenerate = 1'b0;
      owed.push_back(want);
    endfunction

    function void check_unit(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        $error("unit vector arrived with no point outstanding");
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.unit_x !== want.unit_x) begin
        $error("unit_x: expected %0d, got %0d", want.unit_x, got.unit_x);
        errors++;
      end
      if (got.unit_y !== want.unit_y) begin
        $error("unit_y: expected %0d, got %0d", want.unit_y, got.unit_y);
        errors++;
      end
      if (got.unit_z !== want.unit_z) begin
        $error("unit_z: expected %0d, got %0d", want.unit_z, got.unit_z);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
        errors++;
      end
    endfunction

    function void close_out();
      if (owed.size() != 0) begin
        $error("%0d unit vectors never arrived", owed.size());
        errors++;
      end
    endfunction
  endclass
  // --------------------------------------------------------------------------

  logic clk;
  logic rst;
  int   src_idle;
  int   snk_idle;

  vvn_cfg_if cfg_ch ();
  vvn_in_if  pts_ch ();
  vvn_out_if res_ch ();

  unit_vector_board board = new();

  view_vector_normalizer_top uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .pts (pts_ch),
    .res (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result-side backpressure
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(negedge clk) begin
    res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.unit_x     = res_ch.unit_x;
      got.unit_y     = res_ch.unit_y;
      got.unit_z     = res_ch.unit_z;
      got.degenerate = res_ch.degenerate;
      got.last_out   = res_ch.last_out;
      board.check_unit(got);
    end
  end

  // ends the run when no request of any kind moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((pts_ch.valid && pts_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_view_vector_normalizer_top: done, errors");
    $finish;
  end

  function automatic pt_t mk_pt(logic signed [31:0] x, logic signed [31:0] y,
                                logic signed [31:0] z, logic last);
    pt_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    return p;
  endfunction

  function automatic logic signed [31:0] near_coord(logic signed [31:0] s);
    int unsigned w;
    logic [31:0] dm;
    w  = $urandom_range(31);
    dm = $urandom & ((32'h1 << w) - 1);
    return $urandom_range(1) ? s + dm : s - dm;
  endfunction

  function automatic logic signed [31:0] edge_coord(logic signed [31:0] s);
    case ($urandom_range(5))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'sd0;
      3: return s;
      4: return s + 1;
      default: return s - 1;
    endcase
  endfunction

  function automatic pt_t random_pt();
    pt_t p;
    int unsigned kind, ax;
    kind = $urandom_range(99);
    p.last = ($urandom_range(7) == 0);
    if (kind < 40) begin
      p.x = $urandom;
      p.y = $urandom;
      p.z = $urandom;
    end else if (kind < 70) begin
      p.x = near_coord(board.sensor[0]);
      p.y = near_coord(board.sensor[1]);
      p.z = near_coord(board.sensor[2]);
    end else if (kind < 80) begin
      // difference along one axis only
      ax  = $urandom_range(2);
      p.x = (ax == 0) ? near_coord(board.sensor[0]) : board.sensor[0];
      p.y = (ax == 1) ? near_coord(board.sensor[1]) : board.sensor[1];
      p.z = (ax == 2) ? near_coord(board.sensor[2]) : board.sensor[2];
    end else if (kind < 88) begin
      p.x = board.sensor[0];
      p.y = board.sensor[1];
      p.z = board.sensor[2];
    end else begin
      p.x = edge_coord(board.sensor[0]);
      p.y = edge_coord(board.sensor[1]);
      p.z = edge_coord(board.sensor[2]);
    end
    return p;
  endfunction

  // called at a rising edge; leaves valid high after acceptance
  task automatic send_point(input pt_t p);
    if ($urandom_range(99) < src_idle) begin
      pts_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    pts_ch.valid      <= 1'b1;
    pts_ch.point_x    <= p.x;
    pts_ch.point_y    <= p.y;
    pts_ch.point_z    <= p.z;
    pts_ch.last_point <= p.last;
    do @(negedge clk); while (!pts_ch.ready);
    @(posedge clk);
    board.note_point(p);
  endtask

  task automatic drain();
    pts_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // all three sensor registers plus one write to the unmapped index
  task automatic load_sensor(input logic signed [31:0] sx, input logic signed [31:0] sy,
                             input logic signed [31:0] sz);
    logic [31:0]          vals [4];
    logic [CFG_IDX_W-1:0] idx [4];
    vals = '{sx, sy, sz, $urandom};
    idx  = '{REG_SENSOR_X, REG_SENSOR_Y, REG_SENSOR_Z, REG_SPARE};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= vals[i];
      do @(negedge clk); while (!cfg_ch.ready);
      @(posedge clk);
      board.set_reg(idx[i], vals[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_point(random_pt());
    drain();
  endtask

  initial begin
    rst               <= 1'b1;
    pts_ch.valid      <= 1'b0;
    pts_ch.point_x    <= '0;
    pts_ch.point_y    <= '0;
    pts_ch.point_z    <= '0;
    pts_ch.last_point <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    src_idle = 29;
    snk_idle = 64;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sensor at its reset position
    send_point(mk_pt(0, 0, 0, 1'b1));
    send_point(mk_pt(1, 0, 0, 1'b0));
    send_point(mk_pt(0, -1, 0, 1'b0));
    send_point(mk_pt(0, 0, COORD_MIN, 1'b0));
    send_point(mk_pt(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send_point(mk_pt(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
    send_point(mk_pt(1, 1, 1, 1'b0));
    send_point(mk_pt(3, -4, 0, 1'b0));
    send_point(mk_pt(COORD_MAX, COORD_MIN, 1, 1'b1));
    drain();

    // widest differences, both signs
    load_sensor(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(mk_pt(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
    send_point(mk_pt(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send_point(mk_pt(COORD_MIN, COORD_MAX, 0, 1'b0));
    drain();
    load_sensor(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(mk_pt(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
    send_point(mk_pt(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
    send_point(mk_pt(COORD_MAX, COORD_MIN, 0, 1'b1));
    drain();
    load_sensor(COORD_MAX, COORD_MIN, 0);
    send_point(mk_pt(COORD_MIN, COORD_MAX, 0, 1'b0));
    send_point(mk_pt(COORD_MAX, COORD_MIN, 0, 1'b1));
    send_point(mk_pt(32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh0000_0100, 1'b0));
    drain();

    load_sensor($urandom, $urandom, $urandom);
    run_random(PHASE_ITEMS);

    src_idle = 64;
    snk_idle = 29;
    load_sensor($urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
                $urandom_range(2047) - 1024);
    run_random(PHASE_ITEMS);

    src_idle = 0;
    snk_idle = 0;
    load_sensor($urandom, $urandom, $urandom);
    run_random(PHASE_ITEMS);

    board.close_out();
    if (board.errors == 0)
      $display("tb_view_vector_normalizer_top: done, clean");
    else
      $display("tb_view_vector_normalizer_top: done, errors");
    $finish;
  end

endmodule
